>>> src/assert_macros.svh
// assertion macros shared by the controller rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/evp_pkg.sv
// types, constants and helper functions of the velocity pi controller
// no dependencies
`default_nettype none

package evp_pkg;

  localparam int NUM_MOTORS_DEF = 3;

  localparam int SEL_W   = 2;
  localparam int CNT_W   = 32;
  localparam int DT_W    = 16;
  localparam int GAIN_W  = 24;
  localparam int LIM_W   = 16;
  localparam int INTEG_W = 17;
  localparam int DRIVE_W = 18;
  localparam int DUTY_W  = 8;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;
  localparam int FRAC_W  = 16;

  localparam int DIV_W      = 42;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  localparam logic signed [MUL_B_W-1:0] VEL_SCALE   = 25'sd1000;
  localparam logic signed [31:0]        KNOCK_LIMIT = 32'sd100000;
  localparam logic signed [DRIVE_W-1:0] KNOCK_VALUE = 18'sd15;
  localparam logic signed [DRIVE_W-1:0] DUTY_MAX    = 18'sd255;

  localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = 24'sd655;
  localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = 24'sd33;
  localparam logic [LIM_W-1:0]         INTEG_LIM_RST  = 16'd1000;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP   = 2'd0,
    CFG_GAIN_INTEG  = 2'd1,
    CFG_INTEG_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_VEL   = 2'd0,
    MUL_INTVL = 2'd1,
    MUL_KP    = 2'd2,
    MUL_KI    = 2'd3
  } mul_op_t;

  typedef struct packed {
    logic [SEL_W-1:0]        motor_sel;
    logic signed [CNT_W-1:0] encoder_count;
    logic [DT_W-1:0]         elapsed_ms;
    logic signed [31:0]      target_speed;
  } tick_t;

  typedef struct packed {
    logic [SEL_W-1:0]   motor_out;
    logic signed [31:0] measured_speed;
    logic signed [31:0] speed_error;
    logic signed [31:0] drive_accum;
    logic [DUTY_W-1:0]  duty_forward;
    logic [DUTY_W-1:0]  duty_reverse;
    logic               zero_interval;
  } result_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_t mul_op;
    logic    div_init;
    logic    div_step;
    logic    speed_en;
    logic    err_en;
    logic    satp_en;
    logic    integ_en;
    logic    acc_init;
    logic    acc_add;
    logic    drv_en;
    logic    commit;
  } dp_cmd_t;

  typedef struct packed {
    logic sel_ok;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/evp_ctrl.sv
// sequencer of the velocity pi controller: one-hot state machine issuing datapath commands
// depends on evp_pkg
`default_nettype none

module evp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_valid,
  output logic                  tick_stall,
  input  evp_pkg::dp_status_t   status,
  output evp_pkg::dp_cmd_t      cmd
);
  import evp_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_MUL_VEL   = 14'b00000000000010,
    S_DIV_INIT  = 14'b00000000000100,
    S_DIV       = 14'b00000000001000,
    S_SPEED     = 14'b00000000010000,
    S_ERR       = 14'b00000000100000,
    S_MUL_INTVL = 14'b00000001000000,
    S_SAT_P     = 14'b00000010000000,
    S_INTEG     = 14'b00000100000000,
    S_MUL_KP    = 14'b00001000000000,
    S_MUL_KI    = 14'b00010000000000,
    S_SUM       = 14'b00100000000000,
    S_DRIVE     = 14'b01000000000000,
    S_DONE      = 14'b10000000000000
  } state_t;

  state_t                state, state_next;
  logic [STEP_CNT_W-1:0] step, step_next;

  assign tick_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.mul_op = MUL_VEL;
    unique case (state)
      S_IDLE: begin
        if (tick_valid) begin
          cmd.load = 1'b1;
          if (status.sel_ok) begin
            state_next = S_MUL_VEL;
          end
        end
      end
      S_MUL_VEL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_VEL;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_SPEED;
        end
      end
      S_SPEED: begin
        cmd.speed_en = 1'b1;
        state_next   = S_ERR;
      end
      S_ERR: begin
        cmd.err_en = 1'b1;
        state_next = S_MUL_INTVL;
      end
      S_MUL_INTVL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_INTVL;
        state_next = S_SAT_P;
      end
      S_SAT_P: begin
        cmd.satp_en = 1'b1;
        state_next  = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ_en = 1'b1;
        state_next   = S_MUL_KP;
      end
      S_MUL_KP: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = MUL_KP;
        cmd.acc_init = 1'b1;
        state_next   = S_MUL_KI;
      end
      S_MUL_KI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = MUL_KI;
        cmd.acc_add = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        state_next  = S_DRIVE;
      end
      S_DRIVE: begin
        cmd.drv_en = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

`default_nettype wire

>>> src/evp_datapath.sv
// datapath of the velocity pi controller: per-motor state, shared multiplier,
// radix-4 restoring divider, accumulators, config registers and result register
// depends on evp_pkg
`default_nettype none

module evp_datapath #(
  parameter int NUM_MOTORS = evp_pkg::NUM_MOTORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  evp_pkg::tick_t                 tick,
  input  logic                           cfg_we,
  input  logic [evp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evp_pkg::GAIN_W-1:0]     cfg_data,
  input  evp_pkg::dp_cmd_t               cmd,
  output evp_pkg::dp_status_t            status,
  output logic                           result_valid,
  input  logic                           result_stall,
  output evp_pkg::result_t               result
);
  import evp_pkg::*;

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  // config registers
  logic signed [GAIN_W-1:0] gain_prop;
  logic signed [GAIN_W-1:0] gain_integ;
  logic [LIM_W-1:0]         integ_limit;

  // per-motor state
  logic signed [CNT_W-1:0]   prev_count [NUM_MOTORS];
  logic signed [INTEG_W-1:0] integ_mem  [NUM_MOTORS];
  logic signed [DRIVE_W-1:0] drive_mem  [NUM_MOTORS];

  // working registers of the current item
  logic [IDX_W-1:0]          sel_idx;
  logic [SEL_W-1:0]          motor_reg;
  logic signed [CNT_W-1:0]   count_reg;
  logic [DT_W-1:0]           dt_reg;
  logic signed [31:0]        target_reg;
  logic signed [PROD_W-1:0]  prod;
  logic [DIV_W-1:0]          dq;
  logic [DT_W-1:0]           rem;
  logic                      quot_neg;
  logic signed [31:0]        speed_reg;
  logic signed [31:0]        err_reg;
  logic signed [31:0]        p_reg;
  logic signed [INTEG_W-1:0] integ_reg;
  logic signed [ACC_W-1:0]   acc;
  logic signed [31:0]        drv_reg;

  // combinational
  logic [IDX_W+SEL_W-1:0]    sel_ext;
  logic signed [CNT_W-1:0]   diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_mag;
  logic [DT_W:0]             r1, r2;
  logic [DT_W-1:0]           r1s, r2s;
  logic                      ge1, ge2;
  logic signed [DIV_W:0]     quot_s;
  logic signed [33:0]        isum, lim_s, isum_cl;
  logic signed [ACC_W-1:0]   acc_sh, acc_q;
  logic                      acc_rnd;
  logic signed [DRIVE_W-1:0] stored;
  logic [DUTY_W-1:0]         duty_fwd, duty_rev;
  logic                      dt_zero;

  assign sel_ext       = (IDX_W + SEL_W)'(tick.motor_sel);
  assign status.sel_ok = int'(tick.motor_sel) < NUM_MOTORS;
  assign status.out_free = !result_valid || !result_stall;
  assign dt_zero       = (dt_reg == '0);

  assign diff = count_reg - prev_count[sel_idx];

  // shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_op)
      MUL_VEL: begin
        mul_a = MUL_A_W'(diff);
        mul_b = VEL_SCALE;
      end
      MUL_INTVL: begin
        mul_a = MUL_A_W'(err_reg);
        mul_b = $signed(MUL_B_W'(dt_reg));
      end
      MUL_KP: begin
        mul_a = MUL_A_W'(err_reg);
        mul_b = MUL_B_W'(gain_prop);
      end
      MUL_KI: begin
        mul_a = MUL_A_W'(integ_reg);
        mul_b = MUL_B_W'(gain_integ);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_mag = prod[PROD_W-1] ? -prod : prod;

  // two quotient bits per step
  always_comb begin
    r1  = {rem, dq[DIV_W-1]};
    ge1 = (r1 >= {1'b0, dt_reg});
    r1s = ge1 ? DT_W'(r1 - {1'b0, dt_reg}) : r1[DT_W-1:0];
    r2  = {r1s, dq[DIV_W-2]};
    ge2 = (r2 >= {1'b0, dt_reg});
    r2s = ge2 ? DT_W'(r2 - {1'b0, dt_reg}) : r2[DT_W-1:0];
  end

  assign quot_s = quot_neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  always_comb begin
    isum  = 34'(integ_mem[sel_idx]) + 34'(p_reg);
    lim_s = $signed({18'd0, integ_limit});
    if (isum > lim_s) begin
      isum_cl = lim_s;
    end else if (isum < -lim_s) begin
      isum_cl = -lim_s;
    end else begin
      isum_cl = isum;
    end
  end

  // truncation toward zero of acc / 2^16
  assign acc_sh  = acc >>> FRAC_W;
  assign acc_rnd = acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0);
  assign acc_q   = acc_sh + $signed({{(ACC_W-1){1'b0}}, acc_rnd});

  // knock-back and sign-magnitude duties
  always_comb begin
    priority if (drv_reg >= KNOCK_LIMIT) begin
      stored = -KNOCK_VALUE;
    end else if (drv_reg <= -KNOCK_LIMIT) begin
      stored = KNOCK_VALUE;
    end else begin
      stored = drv_reg[DRIVE_W-1:0];
    end
    duty_fwd = '0;
    duty_rev = '0;
    if (stored > 0) begin
      duty_fwd = (stored > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] : stored[DUTY_W-1:0];
    end else if (stored < 0) begin
      duty_rev = (-stored > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] : DUTY_W'(-stored);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop   <= GAIN_PROP_RST;
      gain_integ  <= GAIN_INTEG_RST;
      integ_limit <= INTEG_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_PROP:   gain_prop   <= cfg_data;
        CFG_GAIN_INTEG:  gain_integ  <= cfg_data;
        CFG_INTEG_LIMIT: integ_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        prev_count[i] <= '0;
        integ_mem[i]  <= '0;
        drive_mem[i]  <= '0;
      end
    end else if (cmd.commit) begin
      prev_count[sel_idx] <= count_reg;
      integ_mem[sel_idx]  <= integ_reg;
      drive_mem[sel_idx]  <= stored;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel_idx    <= sel_ext[IDX_W-1:0];
      motor_reg  <= tick.motor_sel;
      count_reg  <= tick.encoder_count;
      dt_reg     <= tick.elapsed_ms;
      target_reg <= tick.target_speed;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.div_init) begin
      dq       <= prod_mag[DIV_W-1:0];
      rem      <= '0;
      quot_neg <= prod[PROD_W-1];
    end else if (cmd.div_step) begin
      dq  <= {dq[DIV_W-3:0], ge1, ge2};
      rem <= r2s;
    end
    if (cmd.speed_en) begin
      speed_reg <= dt_zero ? '0 : sat32(64'(quot_s));
    end
    if (cmd.err_en) begin
      err_reg <= sat32(64'(target_reg) - 64'(speed_reg));
    end
    if (cmd.satp_en) begin
      p_reg <= sat32(64'(prod));
    end
    if (cmd.integ_en) begin
      integ_reg <= isum_cl[INTEG_W-1:0];
    end
    if (cmd.acc_init) begin
      acc <= ACC_W'(drive_mem[sel_idx]) <<< FRAC_W;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end
    if (cmd.drv_en) begin
      drv_reg <= sat32(64'(acc_q));
    end
    if (cmd.commit) begin
      result.motor_out      <= motor_reg;
      result.measured_speed <= speed_reg;
      result.speed_error    <= err_reg;
      result.drive_accum    <= drv_reg;
      result.duty_forward   <= duty_fwd;
      result.duty_reverse   <= duty_rev;
      result.zero_interval  <= dt_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/encoder_velocity_pi_controller.sv
// top level of the per-motor encoder velocity pi controller
// depends on evp_pkg, evp_ctrl, evp_datapath and assert_macros.svh
//
//   channel   direction  handshake              payload
//   tick      in         tick_valid/tick_stall  evp_pkg::tick_t
//   result    out        result_valid/stall     evp_pkg::result_t
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// an item in range runs through the sequencer from acceptance to the result register,
// and its velocity is formed in the two-bit-per-cycle divider
// an item whose motor_sel is out of range is taken and dropped while the sequencer stays idle
// reset clears the gains to their defaults and all per-motor state to zero
// a stalled result holds the sequencer in its last step; the next item is
// taken while the previous result still waits
`default_nettype none

module encoder_velocity_pi_controller #(
  parameter int NUM_MOTORS = evp_pkg::NUM_MOTORS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick_valid,
  output logic                          tick_stall,
  input  evp_pkg::tick_t                tick,
  output logic                          result_valid,
  input  logic                          result_stall,
  output evp_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [evp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [evp_pkg::GAIN_W-1:0]    cfg_data
);
  import evp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  evp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .status     (status),
    .cmd        (cmd)
  );

  evp_datapath #(
    .NUM_MOTORS (NUM_MOTORS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`include "assert_macros.svh"

  `ASSERT_NEXT(a_busy_after_take, clk, rst, tick_valid && !tick_stall && int'(tick.motor_sel) < NUM_MOTORS, tick_stall, "in-range item taken but block not busy")
  `ASSERT_ALWAYS(a_one_side_duty, clk, rst, !result_valid || result.duty_forward == 8'd0 || result.duty_reverse == 8'd0, "both duties nonzero")
  `ASSERT_ALWAYS(a_zero_interval_speed, clk, rst, !result_valid || !result.zero_interval || result.measured_speed == 32'sd0, "zero interval with nonzero speed")
  `ASSERT_ALWAYS(a_knock_back, clk, rst, !(result_valid && result.drive_accum >= 32'sd100000) || (result.duty_reverse == 8'd15 && result.duty_forward == 8'd0), "runaway drive not knocked back")

endmodule

`default_nettype wire
